FILE: sv/hlc_pkg.sv
// Shared widths, types and result codes for the homogeneous line clipper.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hlc_pkg;

  // Coordinate format: signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  // Derived widths
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned DW = CW + 1;                          // difference / divisor
  localparam int unsigned PW = CW + FB + 3;                     // u * direction
  localparam int unsigned NW = (2 * CW > PW) ? 2 * CW : PW;     // dividend
  localparam int unsigned UW = FB + 1;                          // clip parameter in [0, 1.0]

  // One restoring divider: input register, one quotient bit per stage, output register
  localparam int unsigned DIV_LAT  = CW + 2;
  localparam int unsigned PIPE_LEN = 6 + 3 * DIV_LAT;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DW-1:0]   ext_t;
  typedef logic signed [NW-1:0]   num_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [2*CW-1:0] wprod_t;
  typedef logic [1:0]             code_t;

  localparam code_t CODE_INSIDE  = 2'd0;
  localparam code_t CODE_REJECT  = 2'd1;
  localparam code_t CODE_CLIPPED = 2'd2;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t COORD_ONE = coord_t'(1) <<< FB;

endpackage

`default_nettype wire

FILE: sv/hlc_seg_if.sv
// Input channel of the line clipper: one segment as two homogeneous endpoints.
// Depends on hlc_pkg for the coordinate type.
`default_nettype none

interface hlc_seg_if;
  import hlc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t start_w;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;
  coord_t end_w;

  modport source (
    output valid, start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w,
    output ready
  );

endinterface

`default_nettype wire

FILE: sv/hlc_res_if.sv
// Output channel of the line clipper: result code and two normalized endpoints.
// Depends on hlc_pkg for the coordinate and code types.
`default_nettype none

interface hlc_res_if;
  import hlc_pkg::*;

  logic   valid;
  logic   ready;
  code_t  clip_result;
  coord_t first_ndc_x;
  coord_t first_ndc_y;
  coord_t first_ndc_z;
  coord_t second_ndc_x;
  coord_t second_ndc_y;
  coord_t second_ndc_z;

  modport source (
    output valid, clip_result, first_ndc_x, first_ndc_y, first_ndc_z,
           second_ndc_x, second_ndc_y, second_ndc_z,
    input  ready
  );

  modport sink (
    input  valid, clip_result, first_ndc_x, first_ndc_y, first_ndc_z,
           second_ndc_x, second_ndc_y, second_ndc_z,
    output ready
  );

endinterface

`default_nettype wire

FILE: sv/hlc_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, with
// saturation of the quotient to the coordinate range. Depends on hlc_pkg.
`default_nettype none

module hlc_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  hlc_pkg::num_t   num_i,
  input  hlc_pkg::ext_t   den_i,
  output hlc_pkg::coord_t quo_o
);
  import hlc_pkg::*;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [CW-1:0] lo;
    logic [CW-1:0] quo;
    logic [DW-1:0] dm;
    logic          nneg;
    logic          qneg;
    logic          dz;
    logic          ovf;
  } div_st_t;

  div_st_t       st_q [CW+1];
  div_st_t       st0_d;
  logic [NW-1:0] nm;
  logic [DW-1:0] dm;
  logic          nneg;
  logic          dneg;
  coord_t        quo_d;
  coord_t        quo_q;
  logic [CW-1:0] q;

  // Magnitudes, divide-by-zero and quotient overflow
  always_comb begin
    nneg = num_i[NW-1];
    dneg = den_i[DW-1];
    nm   = nneg ? -num_i : num_i;
    dm   = dneg ? -den_i : den_i;
    st0_d.rem  = DW'(nm[NW-1:CW]);
    st0_d.lo   = nm[CW-1:0];
    st0_d.quo  = '0;
    st0_d.dm   = dm;
    st0_d.nneg = nneg;
    st0_d.qneg = nneg ^ dneg;
    st0_d.dz   = (dm == '0);
    st0_d.ovf  = NW'(nm[NW-1:CW]) >= NW'(dm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar i = 0; i < CW; i++) begin : g_step
    logic [DW:0] sh;
    logic        ge;
    div_st_t     nx;

    always_comb begin
      sh       = {st_q[i].rem, st_q[i].lo[CW-1]};
      ge       = sh >= {1'b0, st_q[i].dm};
      nx       = st_q[i];
      nx.rem   = ge ? DW'(sh - {1'b0, st_q[i].dm}) : DW'(sh);
      nx.lo    = st_q[i].lo << 1;
      nx.quo   = {st_q[i].quo[CW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nx;
      end
    end
  end

  // Sign and saturate
  always_comb begin
    q = st_q[CW].quo;
    if (st_q[CW].dz) begin
      quo_d = st_q[CW].nneg ? COORD_MIN : COORD_MAX;
    end else if (st_q[CW].ovf) begin
      quo_d = st_q[CW].qneg ? COORD_MIN : COORD_MAX;
    end else if (st_q[CW].qneg) begin
      quo_d = (q[CW-1] && (q[CW-2:0] != '0)) ? COORD_MIN : coord_t'(-q);
    end else begin
      quo_d = q[CW-1] ? COORD_MAX : coord_t'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

FILE: sv/homogeneous_line_clipper.sv
// Top level of the homogeneous line clipper (Liang-Barsky against |x|,|y| <= w).
// Depends on hlc_pkg, hlc_seg_if, hlc_res_if and hlc_div.
`default_nettype none

// The block takes one segment per clock cycle while seg_i.ready is high and
// returns one result per segment, in order. The pipeline runs through three
// chained banks of restoring dividers, each producing one quotient bit per stage:
// the rescale of the second endpoint to the first endpoint's w, the four
// boundary parameters, and the final projection. Segments wholly inside the
// square ride the same pipeline and use the final divider bank for their
// projection. The whole pipeline advances together; a two-entry output
// register with a skid slot lets the block keep taking segments while one
// finished result waits, and it stalls only once the skid slot is filled.
// Results are saturated to the coordinate range; a rejected segment reports
// all six coordinates as zero.
module homogeneous_line_clipper (
  input  logic      clk_i,
  input  logic      rst_ni,
  hlc_seg_if.sink   seg_i,
  hlc_res_if.source res_o
);
  import hlc_pkg::*;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t sw;
    coord_t ex;
    coord_t ey;
    coord_t ez;
    coord_t ew;
  } seg_t;

  typedef struct packed {
    seg_t   seg;
    logic   all_in;
    wprod_t px;
    wprod_t py;
    wprod_t pz;
  } s1_t;

  typedef struct packed {
    seg_t seg;
    logic all_in;
  } d1_t;

  typedef struct packed {
    seg_t seg;
    logic all_in;
    ext_t run_x;
    ext_t run_y;
    ext_t run_z;
    logic rej;
    logic xpos;
    logic xz;
    logic ypos;
    logic yz;
  } s2_t;

  typedef struct packed {
    s2_t    side;
    coord_t enter;
    coord_t leave;
  } s3_t;

  typedef struct packed {
    seg_t  seg;
    logic  all_in;
    logic  rej;
    prod_t ex_p;
    prod_t ey_p;
    prod_t ez_p;
    prod_t lx_p;
    prod_t ly_p;
    prod_t lz_p;
  } s4_t;

  typedef struct packed {
    code_t  code;
    coord_t f_x;
    coord_t f_y;
    coord_t f_z;
    coord_t s_x;
    coord_t s_y;
    coord_t s_z;
  } res_t;

  // ---------------------------------------------------------------------------
  // Flow control: every stage shares one enable, held low while the skid is full
  // ---------------------------------------------------------------------------
  logic                en;
  logic                in_acc;
  logic [PIPE_LEN-1:0] vld_q;

  logic out_vld_q;
  logic skid_vld_q;
  res_t out_q;
  res_t skid_q;
  res_t fin;
  logic out_take;

  assign en          = !skid_vld_q;
  assign seg_i.ready = en;
  assign in_acc      = seg_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], in_acc};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture the transaction
  // ---------------------------------------------------------------------------
  seg_t p0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q.sx <= seg_i.start_x;
      p0_q.sy <= seg_i.start_y;
      p0_q.sz <= seg_i.start_z;
      p0_q.sw <= seg_i.start_w;
      p0_q.ex <= seg_i.end_x;
      p0_q.ey <= seg_i.end_y;
      p0_q.ez <= seg_i.end_z;
      p0_q.ew <= seg_i.end_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: strict inside test of both endpoints, e * start_w products
  // ---------------------------------------------------------------------------
  s1_t  p1_d;
  s1_t  p1_q;
  ext_t w0;
  ext_t w1;

  always_comb begin
    w0 = DW'(p0_q.sw);
    w1 = DW'(p0_q.ew);
    p1_d.seg    = p0_q;
    p1_d.all_in = (DW'(p0_q.sx) < w0) && (-DW'(p0_q.sx) < w0) &&
                  (DW'(p0_q.sy) < w0) && (-DW'(p0_q.sy) < w0) &&
                  (DW'(p0_q.ex) < w1) && (-DW'(p0_q.ex) < w1) &&
                  (DW'(p0_q.ey) < w1) && (-DW'(p0_q.ey) < w1);
    p1_d.px     = (2*CW)'(p0_q.ex) * (2*CW)'(p0_q.sw);
    p1_d.py     = (2*CW)'(p0_q.ey) * (2*CW)'(p0_q.sw);
    p1_d.pz     = (2*CW)'(p0_q.ez) * (2*CW)'(p0_q.sw);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider bank 1: rescale the second endpoint to the first endpoint's w
  // ---------------------------------------------------------------------------
  num_t   n1 [3];
  coord_t q1 [3];
  d1_t    d1_q [DIV_LAT];

  assign n1[0] = NW'(p1_q.px);
  assign n1[1] = NW'(p1_q.py);
  assign n1[2] = NW'(p1_q.pz);

  for (genvar k = 0; k < 3; k++) begin : g_div1
    hlc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (n1[k]),
      .den_i (DW'(p1_q.seg.ew)),
      .quo_o (q1[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= '{seg: p1_q.seg, all_in: p1_q.all_in};
      for (int i = 1; i < DIV_LAT; i++) begin
        d1_q[i] <= d1_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: direction, boundary distances, zero-denominator rejects
  // ---------------------------------------------------------------------------
  s2_t  p2_d;
  s2_t  p2_q;
  ext_t dist_d [4];
  ext_t dist_q [4];
  seg_t sg2;

  always_comb begin
    sg2         = d1_q[DIV_LAT-1].seg;
    p2_d.seg    = sg2;
    p2_d.all_in = d1_q[DIV_LAT-1].all_in;
    p2_d.run_x  = DW'(q1[0]) - DW'(sg2.sx);
    p2_d.run_y  = DW'(q1[1]) - DW'(sg2.sy);
    p2_d.run_z  = DW'(q1[2]) - DW'(sg2.sz);
    dist_d[0]   = DW'(sg2.sx) + DW'(sg2.sw);
    dist_d[1]   = DW'(sg2.sw) - DW'(sg2.sx);
    dist_d[2]   = DW'(sg2.sy) + DW'(sg2.sw);
    dist_d[3]   = DW'(sg2.sw) - DW'(sg2.sy);
    p2_d.xz     = (p2_d.run_x == '0);
    p2_d.yz     = (p2_d.run_y == '0);
    p2_d.xpos   = !p2_d.run_x[DW-1] && !p2_d.xz;
    p2_d.ypos   = !p2_d.run_y[DW-1] && !p2_d.yz;
    // Parallel to a boundary and on its outer side: nothing survives
    p2_d.rej    = (p2_d.xz && (dist_d[0][DW-1] || dist_d[1][DW-1])) ||
                  (p2_d.yz && (dist_d[2][DW-1] || dist_d[3][DW-1]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q   <= p2_d;
      dist_q <= dist_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider bank 2: boundary parameters distance / denominator
  // ---------------------------------------------------------------------------
  ext_t   den2 [4];
  coord_t q2 [4];
  s2_t    d2_q [DIV_LAT];

  assign den2[0] = -p2_q.run_x;
  assign den2[1] = p2_q.run_x;
  assign den2[2] = -p2_q.run_y;
  assign den2[3] = p2_q.run_y;

  for (genvar k = 0; k < 4; k++) begin : g_div2
    hlc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (NW'(dist_q[k]) <<< FB),
      .den_i (den2[k]),
      .quo_o (q2[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q[0] <= p2_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        d2_q[i] <= d2_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: entry parameter (max) and exit parameter (min)
  // ---------------------------------------------------------------------------
  s3_t    p3_d;
  s3_t    p3_q;
  s2_t    sd3;
  coord_t x_in;
  coord_t x_out;
  coord_t y_in;
  coord_t y_out;
  coord_t ent_x;
  coord_t lv_x;

  always_comb begin
    sd3   = d2_q[DIV_LAT-1];
    // A negative denominator raises the entry, a positive one lowers the exit
    x_in  = sd3.xpos ? q2[0] : q2[1];
    x_out = sd3.xpos ? q2[1] : q2[0];
    y_in  = sd3.ypos ? q2[2] : q2[3];
    y_out = sd3.ypos ? q2[3] : q2[2];
    ent_x = (!sd3.xz && (x_in > coord_t'(0))) ? x_in : coord_t'(0);
    lv_x  = (!sd3.xz && (x_out < COORD_ONE)) ? x_out : COORD_ONE;
    p3_d.side  = sd3;
    p3_d.enter = (!sd3.yz && (y_in > ent_x)) ? y_in : ent_x;
    p3_d.leave = (!sd3.yz && (y_out < lv_x)) ? y_out : lv_x;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q <= p3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final reject, u * direction products
  // ---------------------------------------------------------------------------
  s4_t   p4_d;
  s4_t   p4_q;
  prod_t ue;
  prod_t ul;

  // A surviving segment has 0 <= enter <= leave <= 1.0; truncate to UW bits
  always_comb begin
    ue = PW'(signed'({1'b0, p3_q.enter[UW-1:0]}));
    ul = PW'(signed'({1'b0, p3_q.leave[UW-1:0]}));
    p4_d.seg    = p3_q.side.seg;
    p4_d.all_in = p3_q.side.all_in;
    p4_d.rej    = p3_q.side.rej || (p3_q.enter > p3_q.leave);
    p4_d.ex_p   = ue * PW'(p3_q.side.run_x);
    p4_d.ey_p   = ue * PW'(p3_q.side.run_y);
    p4_d.ez_p   = ue * PW'(p3_q.side.run_z);
    p4_d.lx_p   = ul * PW'(p3_q.side.run_x);
    p4_d.ly_p   = ul * PW'(p3_q.side.run_y);
    p4_d.lz_p   = ul * PW'(p3_q.side.run_z);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q <= p4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: dividends and divisors of the final projection
  // ---------------------------------------------------------------------------
  num_t  n5_d [6];
  num_t  n5_q [6];
  ext_t  w5_d [6];
  ext_t  w5_q [6];
  code_t code5_d;
  code_t code5_q;
  num_t  bx;
  num_t  by;
  num_t  bz;

  always_comb begin
    bx = NW'(p4_q.seg.sx) <<< FB;
    by = NW'(p4_q.seg.sy) <<< FB;
    bz = NW'(p4_q.seg.sz) <<< FB;
    if (p4_q.all_in) begin
      // Each endpoint divided by its own w
      n5_d[0] = bx;
      n5_d[1] = by;
      n5_d[2] = bz;
      n5_d[3] = NW'(p4_q.seg.ex) <<< FB;
      n5_d[4] = NW'(p4_q.seg.ey) <<< FB;
      n5_d[5] = NW'(p4_q.seg.ez) <<< FB;
      for (int k = 0; k < 3; k++) begin
        w5_d[k]   = DW'(p4_q.seg.sw);
        w5_d[k+3] = DW'(p4_q.seg.ew);
      end
      code5_d = CODE_INSIDE;
    end else begin
      // Point along the segment, divided by the first w
      n5_d[0] = bx + NW'(p4_q.ex_p);
      n5_d[1] = by + NW'(p4_q.ey_p);
      n5_d[2] = bz + NW'(p4_q.ez_p);
      n5_d[3] = bx + NW'(p4_q.lx_p);
      n5_d[4] = by + NW'(p4_q.ly_p);
      n5_d[5] = bz + NW'(p4_q.lz_p);
      for (int k = 0; k < 6; k++) begin
        w5_d[k] = DW'(p4_q.seg.sw);
      end
      code5_d = p4_q.rej ? CODE_REJECT : CODE_CLIPPED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q    <= n5_d;
      w5_q    <= w5_d;
      code5_q <= code5_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider bank 3: normalized coordinates
  // ---------------------------------------------------------------------------
  coord_t q3 [6];
  code_t  d3_q [DIV_LAT];

  for (genvar k = 0; k < 6; k++) begin : g_div3
    hlc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (n5_q[k]),
      .den_i (w5_q[k]),
      .quo_o (q3[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q[0] <= code5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        d3_q[i] <= d3_q[i-1];
      end
    end
  end

  // Drop the coordinates of a rejected segment to zero
  always_comb begin
    fin.code = d3_q[DIV_LAT-1];
    if (d3_q[DIV_LAT-1] == CODE_REJECT) begin
      fin.f_x = '0;
      fin.f_y = '0;
      fin.f_z = '0;
      fin.s_x = '0;
      fin.s_y = '0;
      fin.s_z = '0;
    end else begin
      fin.f_x = q3[0];
      fin.f_y = q3[1];
      fin.f_z = q3[2];
      fin.s_x = q3[3];
      fin.s_y = q3[4];
      fin.s_z = q3[5];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid slot
  // ---------------------------------------------------------------------------
  assign out_take = out_vld_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // Pipeline is held; drain the skid slot first
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_q[PIPE_LEN-1]) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (vld_q[PIPE_LEN-1]) begin
      if (!out_vld_q || out_take) begin
        out_q <= fin;
      end else begin
        skid_q <= fin;
      end
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.clip_result  = out_q.code;
  assign res_o.first_ndc_x  = out_q.f_x;
  assign res_o.first_ndc_y  = out_q.f_y;
  assign res_o.first_ndc_z  = out_q.f_z;
  assign res_o.second_ndc_x = out_q.s_x;
  assign res_o.second_ndc_y = out_q.s_y;
  assign res_o.second_ndc_z = out_q.s_z;

endmodule

`default_nettype wire
